FILE: hdl/wted_pkg.sv
// Shared constants, types and arithmetic helpers for the weighted tree edit distance block.
`timescale 1ns / 1ps

package wted_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int NUM_TYPES_DEF = 8;

  localparam int DIST_W = 23;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    MODE_COST  = 2'd0,
    MODE_NODE1 = 2'd1,
    MODE_NODE2 = 2'd2,
    MODE_RUN   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0] ntype;
    logic [7:0] weight;
    logic [6:0] leaf;
  } node_t;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] x,
                                                input logic [DIST_W-1:0] y);
    logic [DIST_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] dmin(input logic [DIST_W-1:0] x,
                                             input logic [DIST_W-1:0] y);
    return (x < y) ? x : y;
  endfunction

endpackage

FILE: hdl/weighted_tree_edit_distance.sv
// Weighted tree edit distance engine: table loads, keyroot search and pair recurrence.
`timescale 1ns / 1ps
// Usage. Input transactions carry a mode. Mode 0 writes one cost table entry, modes 1 and 2
// write one postorder node of the first or second tree, and mode 3 starts a distance run on
// the two sizes given. Loads are taken one per cycle while idle and give no result. A run
// gives exactly one output transaction carrying the distance of the whole trees.
// A run first clears the subtree store, one entry a cycle, all (MAX_NODES+1)^2 entries. The
// keyroot search then reads, checks and marks each node of each tree in turn. Every keyroot
// pair (i, j) passes through its setup states, fills the boundary column and row of the
// forest table node by node, then fills each row cell by cell; each memory has a single read
// port. The answer is then read from the subtree store. During a run in_stall stays high.
// The result sits in an output register; loads and a new run are accepted while it waits.
// A run that finishes while an earlier result is still stalled holds until that one is taken.
// Reset is synchronous and active low; it empties the output register and returns the
// sequencer to idle. Table contents are not cleared by reset and must be loaded before use.
module weighted_tree_edit_distance
  import wted_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int NUM_TYPES = NUM_TYPES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [6:0]        in_slot,
  input  logic [2:0]        in_column,
  input  logic [2:0]        in_node_type,
  input  logic [7:0]        in_node_weight,
  input  logic [6:0]        in_leftmost_leaf,
  input  logic [7:0]        in_cost_value,
  input  logic [6:0]        in_first_size,
  input  logic [6:0]        in_second_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DIST_W-1:0] out_distance
);

  localparam int SIDE = MAX_NODES + 1;
  localparam int IW   = $clog2(SIDE);
  localparam int KW   = $clog2(MAX_NODES);
  localparam int TW   = $clog2(NUM_TYPES);
  localparam int FDEP = SIDE * SIDE;
  localparam int AW   = $clog2(FDEP);
  localparam int SW   = IW + 1;
  localparam int SDEP = 2 ** SW;
  localparam int CDEP = 2 ** (2 * TW);
  localparam int PW   = 16;

  typedef enum logic [23:0] {
    S_IDLE      = 24'h000001,
    S_CLR       = 24'h000002,
    S_KR_NODE   = 24'h000004,
    S_KR_SEEN   = 24'h000008,
    S_KR_MARK   = 24'h000010,
    S_PAIR_RD   = 24'h000020,
    S_PAIR_NODE = 24'h000040,
    S_PAIR_LEAF = 24'h000080,
    S_COL_N     = 24'h000100,
    S_COL_C     = 24'h000200,
    S_COL_W     = 24'h000400,
    S_ROW_N     = 24'h000800,
    S_ROW_C     = 24'h001000,
    S_ROW_W     = 24'h002000,
    S_A_N       = 24'h004000,
    S_A_C       = 24'h008000,
    S_A_D       = 24'h010000,
    S_B_N       = 24'h020000,
    S_B_C       = 24'h040000,
    S_B_D       = 24'h080000,
    S_B_E       = 24'h100000,
    S_B_W       = 24'h200000,
    S_RES_RD    = 24'h400000,
    S_RES       = 24'h800000
  } state_t;

  function automatic logic [IW-1:0] san_leaf(input logic [6:0] l, input logic [IW-1:0] k);
    return (l != 7'd0 && 32'(l) <= 32'(k)) ? IW'(l) : k;
  endfunction

  function automatic logic [TW-1:0] san_type(input logic [2:0] t);
    return (32'(t) < NUM_TYPES) ? TW'(t) : '0;
  endfunction

  function automatic logic [IW-1:0] clamp_size(input logic [6:0] s);
    logic [IW-1:0] r;
    if (s == 7'd0) begin
      r = IW'(1);
    end else if (32'(s) > MAX_NODES) begin
      r = IW'(MAX_NODES);
    end else begin
      r = IW'(s);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] lin(input logic [IW-1:0] a, input logic [IW-1:0] b);
    return AW'(a) * AW'(SIDE) + AW'(b);
  endfunction

  // Memories and their ports.
  logic [DIST_W-1:0] fd_mem [FDEP];
  logic [DIST_W-1:0] st_mem [FDEP];
  node_t             n1_mem [SIDE];
  node_t             n2_mem [SIDE];
  logic [IW-1:0]     kr1_mem [MAX_NODES];
  logic [IW-1:0]     kr2_mem [MAX_NODES];
  logic              seen_mem [SDEP];
  logic [7:0]        cost_mem [CDEP];

  logic [AW-1:0]     fd_ra, fd_wa, st_ra, st_wa;
  logic              fd_we, st_we;
  logic [DIST_W-1:0] fd_wd, st_wd, fd_rd_r, st_rd_r;
  logic [IW-1:0]     n1_ra, n2_ra, n_wa;
  logic              n1_we, n2_we;
  node_t             n_wd, n1_rd_r, n2_rd_r;
  logic [KW-1:0]     kr1_ra, kr2_ra, kr_wa;
  logic              kr1_we, kr2_we;
  logic [IW-1:0]     kr_wd, kr1_rd_r, kr2_rd_r;
  logic [SW-1:0]     seen_ra, seen_wa;
  logic              seen_we, seen_wd, seen_rd_r;
  logic [2*TW-1:0]   cost_ra, cost_wa;
  logic              cost_we;
  logic [7:0]        cost_rd_r;

  // Control and datapath registers.
  state_t            state_r, state_nxt;
  logic              tree_r, tree_nxt;
  logic [IW-1:0]     k_r, k_nxt, l_r, l_nxt;
  logic [IW-1:0]     kc1_r, kc1_nxt, kc2_r, kc2_nxt;
  logic [KW-1:0]     px_r, px_nxt, py_r, py_nxt;
  logic [IW-1:0]     i_r, i_nxt, j_r, j_nxt, li_r, li_nxt, lj_r, lj_nxt;
  logic [IW-1:0]     a_r, a_nxt, b_r, b_nxt, la_r, la_nxt, lb_r, lb_nxt;
  logic [TW-1:0]     ta_r, ta_nxt, tb_r, tb_nxt;
  logic [7:0]        wa_r, wa_nxt, wb_r, wb_nxt;
  logic [7:0]        c0a_r, c0a_nxt, c0b_r, c0b_nxt;
  logic [PW-1:0]     dcost_r, dcost_nxt, ins_r, ins_nxt, m1_r, m1_nxt, m2_r, m2_nxt;
  logic [DIST_W-1:0] up_r, up_nxt, left_r, left_nxt, diag_r, diag_nxt;
  logic [DIST_W-1:0] g_r, g_nxt, f_r, f_nxt, acc_r, acc_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [IW-1:0]     n1s_r, n1s_nxt, n2s_r, n2s_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_distance_r, out_distance_nxt;

  // Helper signals.
  logic              in_acc;
  node_t             n_sel;
  logic [IW-1:0]     kr_leaf, pa, pb, ra, rb;
  logic [TW-1:0]     ta_c, tb_c;
  logic              match, wa_le;
  logic [7:0]        lo, diff, cd;
  logic [PW-1:0]     pa_prod, pb_prod, m1_c, m2_c;
  logic [PW:0]       msum;
  logic [DIST_W-1:0] col_sum, row_sum, g_match, cell_res;

  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

  // Load writes.
  assign cost_we = in_acc && (in_mode == MODE_COST) && (32'(in_slot) < NUM_TYPES) &&
                   (32'(in_column) < NUM_TYPES);
  assign cost_wa = {TW'(in_slot), TW'(in_column)};
  assign n1_we   = in_acc && (in_mode == MODE_NODE1) && (in_slot != 7'd0) &&
                   (32'(in_slot) <= MAX_NODES);
  assign n2_we   = in_acc && (in_mode == MODE_NODE2) && (in_slot != 7'd0) &&
                   (32'(in_slot) <= MAX_NODES);
  assign n_wa    = IW'(in_slot);
  assign n_wd    = '{ntype: in_node_type, weight: in_node_weight, leaf: in_leftmost_leaf};

  assign n_sel   = tree_r ? n2_rd_r : n1_rd_r;
  assign kr_leaf = san_leaf(n_sel.leaf, k_r);
  assign ta_c    = san_type(n1_rd_r.ntype);
  assign tb_c    = san_type(n2_rd_r.ntype);

  assign pa    = (a_r == li_r) ? '0 : a_r - 1'b1;
  assign pb    = (b_r == lj_r) ? '0 : b_r - 1'b1;
  assign ra    = (la_r > li_r) ? la_r - 1'b1 : '0;
  assign rb    = (lb_r > lj_r) ? lb_r - 1'b1 : '0;
  assign match = (la_r == li_r) && (lb_r == lj_r);

  // The heavier node decides which deletion or insertion cost scales the weight gap.
  assign wa_le = (wa_r <= wb_r);
  assign lo    = wa_le ? wa_r : wb_r;
  assign diff  = wa_le ? (wb_r - wa_r) : (wa_r - wb_r);
  assign cd    = wa_le ? c0b_r : c0a_r;

  assign pa_prod = cost_rd_r * wa_r;
  assign pb_prod = cost_rd_r * wb_r;
  assign m1_c    = cost_rd_r * lo;
  assign m2_c    = cd * diff;
  assign msum    = {1'b0, m1_r} + {1'b0, m2_r};

  assign col_sum  = sat_add(acc_r, {{(DIST_W-PW){1'b0}}, pa_prod});
  assign row_sum  = sat_add(acc_r, {{(DIST_W-PW){1'b0}}, pb_prod});
  assign g_match  = sat_add(diag_r, {{(DIST_W-PW-1){1'b0}}, msum});
  assign cell_res = match ? dmin(f_r, g_match) : dmin(f_r, g_r);

  always_comb begin
    state_nxt        = state_r;
    tree_nxt         = tree_r;
    k_nxt            = k_r;
    l_nxt            = l_r;
    kc1_nxt          = kc1_r;
    kc2_nxt          = kc2_r;
    px_nxt           = px_r;
    py_nxt           = py_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    li_nxt           = li_r;
    lj_nxt           = lj_r;
    a_nxt            = a_r;
    b_nxt            = b_r;
    la_nxt           = la_r;
    lb_nxt           = lb_r;
    ta_nxt           = ta_r;
    tb_nxt           = tb_r;
    wa_nxt           = wa_r;
    wb_nxt           = wb_r;
    c0a_nxt          = c0a_r;
    c0b_nxt          = c0b_r;
    dcost_nxt        = dcost_r;
    ins_nxt          = ins_r;
    m1_nxt           = m1_r;
    m2_nxt           = m2_r;
    up_nxt           = up_r;
    left_nxt         = left_r;
    diag_nxt         = diag_r;
    g_nxt            = g_r;
    f_nxt            = f_r;
    acc_nxt          = acc_r;
    clr_nxt          = clr_r;
    n1s_nxt          = n1s_r;
    n2s_nxt          = n2s_r;
    out_valid_nxt    = out_valid_r;
    out_distance_nxt = out_distance_r;

    fd_ra   = '0;
    fd_wa   = '0;
    fd_we   = 1'b0;
    fd_wd   = '0;
    st_ra   = '0;
    st_wa   = '0;
    st_we   = 1'b0;
    st_wd   = '0;
    n1_ra   = '0;
    n2_ra   = '0;
    kr1_ra  = '0;
    kr2_ra  = '0;
    kr_wa   = '0;
    kr1_we  = 1'b0;
    kr2_we  = 1'b0;
    kr_wd   = k_r;
    seen_ra = '0;
    seen_wa = '0;
    seen_we = 1'b0;
    seen_wd = 1'b0;
    cost_ra = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && in_mode == MODE_RUN) begin
          n1s_nxt   = clamp_size(in_first_size);
          n2s_nxt   = clamp_size(in_second_size);
          clr_nxt   = '0;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        st_we   = 1'b1;
        st_wa   = clr_r;
        seen_we = (32'(clr_r) < SDEP);
        seen_wa = SW'(clr_r);
        if (32'(clr_r) == FDEP - 1) begin
          tree_nxt  = 1'b0;
          k_nxt     = n1s_r;
          kc1_nxt   = '0;
          kc2_nxt   = '0;
          state_nxt = S_KR_NODE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_KR_NODE: begin
        n1_ra     = k_r;
        n2_ra     = k_r;
        state_nxt = S_KR_SEEN;
      end
      S_KR_SEEN: begin
        seen_ra   = {tree_r, kr_leaf};
        l_nxt     = kr_leaf;
        state_nxt = S_KR_MARK;
      end
      S_KR_MARK: begin
        // Nodes are scanned from the last one down, so the first node to claim a leaf is
        // the keyroot; lists are therefore stored in descending order.
        seen_we = 1'b1;
        seen_wa = {tree_r, l_r};
        seen_wd = 1'b1;
        if (!seen_rd_r) begin
          if (tree_r) begin
            kr2_we  = 1'b1;
            kr_wa   = KW'(kc2_r);
            kc2_nxt = kc2_r + 1'b1;
          end else begin
            kr1_we  = 1'b1;
            kr_wa   = KW'(kc1_r);
            kc1_nxt = kc1_r + 1'b1;
          end
        end
        if (k_r == IW'(1)) begin
          if (!tree_r) begin
            tree_nxt  = 1'b1;
            k_nxt     = n2s_r;
            state_nxt = S_KR_NODE;
          end else begin
            px_nxt    = KW'(kc1_r - 1'b1);
            py_nxt    = KW'(kc2_nxt - 1'b1);
            state_nxt = S_PAIR_RD;
          end
        end else begin
          k_nxt     = k_r - 1'b1;
          state_nxt = S_KR_NODE;
        end
      end
      S_PAIR_RD: begin
        kr1_ra    = px_r;
        kr2_ra    = py_r;
        state_nxt = S_PAIR_NODE;
      end
      S_PAIR_NODE: begin
        i_nxt     = kr1_rd_r;
        j_nxt     = kr2_rd_r;
        n1_ra     = kr1_rd_r;
        n2_ra     = kr2_rd_r;
        state_nxt = S_PAIR_LEAF;
      end
      S_PAIR_LEAF: begin
        li_nxt    = san_leaf(n1_rd_r.leaf, i_r);
        lj_nxt    = san_leaf(n2_rd_r.leaf, j_r);
        fd_we     = 1'b1;
        fd_wa     = lin('0, '0);
        acc_nxt   = '0;
        a_nxt     = li_nxt;
        state_nxt = S_COL_N;
      end
      S_COL_N: begin
        n1_ra     = a_r;
        state_nxt = S_COL_C;
      end
      S_COL_C: begin
        wa_nxt    = n1_rd_r.weight;
        cost_ra   = {{TW{1'b0}}, ta_c};
        state_nxt = S_COL_W;
      end
      S_COL_W: begin
        fd_we = 1'b1;
        fd_wa = lin(a_r, '0);
        fd_wd = col_sum;
        if (a_r == i_r) begin
          acc_nxt   = '0;
          b_nxt     = lj_r;
          state_nxt = S_ROW_N;
        end else begin
          acc_nxt   = col_sum;
          a_nxt     = a_r + 1'b1;
          state_nxt = S_COL_N;
        end
      end
      S_ROW_N: begin
        n2_ra     = b_r;
        state_nxt = S_ROW_C;
      end
      S_ROW_C: begin
        wb_nxt    = n2_rd_r.weight;
        cost_ra   = {{TW{1'b0}}, tb_c};
        state_nxt = S_ROW_W;
      end
      S_ROW_W: begin
        fd_we = 1'b1;
        fd_wa = lin('0, b_r);
        fd_wd = row_sum;
        if (b_r == j_r) begin
          a_nxt     = li_r;
          state_nxt = S_A_N;
        end else begin
          acc_nxt   = row_sum;
          b_nxt     = b_r + 1'b1;
          state_nxt = S_ROW_N;
        end
      end
      S_A_N: begin
        n1_ra     = a_r;
        state_nxt = S_A_C;
      end
      S_A_C: begin
        ta_nxt    = ta_c;
        wa_nxt    = n1_rd_r.weight;
        la_nxt    = san_leaf(n1_rd_r.leaf, a_r);
        cost_ra   = {{TW{1'b0}}, ta_c};
        state_nxt = S_A_D;
      end
      S_A_D: begin
        c0a_nxt   = cost_rd_r;
        dcost_nxt = pa_prod;
        b_nxt     = lj_r;
        state_nxt = S_B_N;
      end
      S_B_N: begin
        n2_ra     = b_r;
        fd_ra     = lin(pa, b_r);
        state_nxt = S_B_C;
      end
      S_B_C: begin
        tb_nxt    = tb_c;
        wb_nxt    = n2_rd_r.weight;
        lb_nxt    = san_leaf(n2_rd_r.leaf, b_r);
        up_nxt    = fd_rd_r;
        cost_ra   = {{TW{1'b0}}, tb_c};
        fd_ra     = lin(a_r, pb);
        state_nxt = S_B_D;
      end
      S_B_D: begin
        c0b_nxt   = cost_rd_r;
        ins_nxt   = pb_prod;
        left_nxt  = fd_rd_r;
        cost_ra   = {ta_r, tb_r};
        fd_ra     = match ? lin(pa, pb) : lin(ra, rb);
        st_ra     = lin(a_r, b_r);
        state_nxt = S_B_E;
      end
      S_B_E: begin
        diag_nxt  = fd_rd_r;
        g_nxt     = sat_add(fd_rd_r, st_rd_r);
        f_nxt     = dmin(sat_add(up_r, {{(DIST_W-PW){1'b0}}, dcost_r}),
                         sat_add(left_r, {{(DIST_W-PW){1'b0}}, ins_r}));
        m1_nxt    = m1_c;
        m2_nxt    = m2_c;
        state_nxt = S_B_W;
      end
      S_B_W: begin
        fd_we = 1'b1;
        fd_wa = lin(a_r, b_r);
        fd_wd = cell_res;
        st_we = match;
        st_wa = lin(a_r, b_r);
        st_wd = cell_res;
        if (b_r != j_r) begin
          b_nxt     = b_r + 1'b1;
          state_nxt = S_B_N;
        end else if (a_r != i_r) begin
          a_nxt     = a_r + 1'b1;
          state_nxt = S_A_N;
        end else if (py_r != '0) begin
          py_nxt    = py_r - 1'b1;
          state_nxt = S_PAIR_RD;
        end else if (px_r != '0) begin
          px_nxt    = px_r - 1'b1;
          py_nxt    = KW'(kc2_r - 1'b1);
          state_nxt = S_PAIR_RD;
        end else begin
          state_nxt = S_RES_RD;
        end
      end
      S_RES_RD: begin
        st_ra     = lin(n1s_r, n2s_r);
        state_nxt = S_RES;
      end
      S_RES: begin
        st_ra = lin(n1s_r, n2s_r);
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_distance_nxt = st_rd_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tree_r         <= tree_nxt;
    k_r            <= k_nxt;
    l_r            <= l_nxt;
    kc1_r          <= kc1_nxt;
    kc2_r          <= kc2_nxt;
    px_r           <= px_nxt;
    py_r           <= py_nxt;
    i_r            <= i_nxt;
    j_r            <= j_nxt;
    li_r           <= li_nxt;
    lj_r           <= lj_nxt;
    a_r            <= a_nxt;
    b_r            <= b_nxt;
    la_r           <= la_nxt;
    lb_r           <= lb_nxt;
    ta_r           <= ta_nxt;
    tb_r           <= tb_nxt;
    wa_r           <= wa_nxt;
    wb_r           <= wb_nxt;
    c0a_r          <= c0a_nxt;
    c0b_r          <= c0b_nxt;
    dcost_r        <= dcost_nxt;
    ins_r          <= ins_nxt;
    m1_r           <= m1_nxt;
    m2_r           <= m2_nxt;
    up_r           <= up_nxt;
    left_r         <= left_nxt;
    diag_r         <= diag_nxt;
    g_r            <= g_nxt;
    f_r            <= f_nxt;
    acc_r          <= acc_nxt;
    clr_r          <= clr_nxt;
    n1s_r          <= n1s_nxt;
    n2s_r          <= n2s_nxt;
    out_distance_r <= out_distance_nxt;
  end

  always_ff @(posedge clk) begin
    if (fd_we) begin
      fd_mem[fd_wa] <= fd_wd;
    end
    fd_rd_r <= fd_mem[fd_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    st_rd_r <= st_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (n1_we) begin
      n1_mem[n_wa] <= n_wd;
    end
    n1_rd_r <= n1_mem[n1_ra];
  end

  always_ff @(posedge clk) begin
    if (n2_we) begin
      n2_mem[n_wa] <= n_wd;
    end
    n2_rd_r <= n2_mem[n2_ra];
  end

  always_ff @(posedge clk) begin
    if (kr1_we) begin
      kr1_mem[kr_wa] <= kr_wd;
    end
    kr1_rd_r <= kr1_mem[kr1_ra];
  end

  always_ff @(posedge clk) begin
    if (kr2_we) begin
      kr2_mem[kr_wa] <= kr_wd;
    end
    kr2_rd_r <= kr2_mem[kr2_ra];
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    seen_rd_r <= seen_mem[seen_ra];
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_wa] <= in_cost_value;
    end
    cost_rd_r <= cost_mem[cost_ra];
  end

endmodule
